[rtl/core/utd_pkg.sv]
// ----------------------------------------------------------------------------
// utd_pkg
// Shared types and constants for the UTF-8 to 16-bit code point decoder.
// ----------------------------------------------------------------------------
package utd_pkg;

    // Continuation bytes still awaited
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;

    // Lead byte masks and patterns
    localparam logic [7:0] ASCII_MASK = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;

    // Decoder state carried from byte to byte
    typedef struct packed {
        logic [1:0] pending;
        logic [9:0] partial;
    } t_state;

    // One result item
    typedef struct packed {
        logic [15:0] code_point;
        logic        last_char;
        logic        truncated;
    } t_result;

endpackage

[rtl/core/utd_step.sv]
// ----------------------------------------------------------------------------
// utd_step
// Combinational decode of one byte against the current decoder state.
// ----------------------------------------------------------------------------
module utd_step import utd_pkg::*; (
    input  t_state     i_state,
    input  logic [7:0] i_byte_in,
    input  logic       i_is_last,
    output t_state     o_state,
    output logic       o_emit,
    output t_result    o_result
);

    t_result w_trunc;

    assign w_trunc = '{code_point: 16'd0, last_char: 1'b1, truncated: 1'b1};

    // Decode the byte
    always_comb begin
        o_state  = '{pending: PEND_NONE, partial: 10'd0};
        o_emit   = 1'b0;
        o_result = w_trunc;
        priority if (i_state.pending == PEND_ONE) begin
            // Final continuation: close the character
            o_emit   = 1'b1;
            o_result = '{code_point: {i_state.partial, i_byte_in[5:0]},
                         last_char:  i_is_last, truncated: 1'b0};
        end else if (i_state.pending == PEND_TWO) begin
            // Middle continuation: gather six more bits
            if (i_is_last) begin
                o_emit = 1'b1;
            end else begin
                o_state = '{pending: PEND_ONE,
                            partial: {i_state.partial[3:0], i_byte_in[5:0]}};
            end
        end else begin
            // No sequence open
            if ((i_byte_in & ASCII_MASK) == 8'h00) begin
                o_emit   = 1'b1;
                o_result = '{code_point: {8'd0, i_byte_in},
                             last_char:  i_is_last, truncated: 1'b0};
            end else begin
                if (!i_is_last) begin
                    if ((i_byte_in & LEAD2_MASK) == LEAD2_PAT) begin
                        o_state = '{pending: PEND_ONE,
                                    partial: {5'd0, i_byte_in[4:0]}};
                    end else if ((i_byte_in & LEAD3_MASK) == LEAD3_PAT) begin
                        o_state = '{pending: PEND_TWO,
                                    partial: {6'd0, i_byte_in[3:0]}};
                    end
                end
                // A lead or skipped byte marked last ends the string truncated
                o_emit = i_is_last;
            end
        end
    end

endmodule

[rtl/core/utf8_to_ucs2_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder
// UTF-8 byte stream to 16-bit basic-plane code point decoder.
// ----------------------------------------------------------------------------
//  channel | valid   | ready   | payload
//  input   | i_valid | o_ready | i_byte_in, i_is_last
//  output  | o_valid | i_ready | o_code_point, o_last_char, o_truncated
//
//  One byte per cycle while o_ready is high; each result is registered.
//  Decode is one pass of shallow logic from the state register to the
//  output register; a skid register behind the output takes one more
//  result during an output stall, and o_ready drops while it is full.
//  Synchronous active-low reset clears the sequence state and both valids.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder import utd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte_in,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_code_point,
    output logic        o_last_char,
    output logic        o_truncated
);

    t_state  r_state;
    t_state  n_state;
    logic    w_emit;
    t_result w_result;
    logic    w_in_xfer;

    logic    r_out_vld;
    t_result r_out;
    logic    r_skid_vld;
    t_result r_skid;

    assign o_ready   = !r_skid_vld;
    assign w_in_xfer = i_valid && o_ready;

    utd_step u_step (
        .i_state   (r_state),
        .i_byte_in (i_byte_in),
        .i_is_last (i_is_last),
        .o_state   (n_state),
        .o_emit    (w_emit),
        .o_result  (w_result)
    );

    // Advance the sequence state on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{pending: PEND_NONE, partial: 10'd0};
        end else if (w_in_xfer) begin
            r_state <= n_state;
        end
    end

    // Output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_ready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= w_in_xfer && w_emit;
            end
        end else if (w_in_xfer && w_emit) begin
            r_skid_vld <= 1'b1;
        end
    end

    // Payload moves without reset
    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_ready) begin
            r_out <= r_skid_vld ? r_skid : w_result;
        end else if (w_in_xfer && w_emit) begin
            r_skid <= w_result;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_code_point = r_out.code_point;
    assign o_last_char  = r_out.last_char;
    assign o_truncated  = r_out.truncated;

endmodule

[rtl/core/utd_checker.sv]
// ----------------------------------------------------------------------------
// utd_checker
// Port-level checks for the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module utd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_code_point,
    input logic        o_last_char,
    input logic        o_truncated
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_code_point))
        else $error("result dropped or changed while stalled");

    // Truncated results carry a zero code point
    a_trunc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_truncated |-> o_code_point == 16'd0)
        else $error("truncated result with nonzero code point");

    // Truncation only happens at the end of a string
    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_truncated |-> o_last_char)
        else $error("truncated result not marked last");

    // Input closes only when a result is stalled
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !$past(i_ready))
        else $error("input closed without an output stall");

endmodule

bind utf8_to_ucs2_decoder utd_checker u_utd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_code_point (o_code_point),
    .o_last_char  (o_last_char),
    .o_truncated  (o_truncated)
);
